[sv/v4s_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared types, sizes and step functions of the four-component vector scaler.
// Used by the front, queue, back and top-level modules.
package v4s_pkg;
  localparam int unsigned CompW  = 24;
  localparam int unsigned Lanes  = 4;
  localparam int unsigned ProdW  = 2 * CompW;
  localparam int unsigned RadW   = 2 * CompW + 2;
  localparam int unsigned RootW  = CompW + 1;
  localparam int unsigned SremW  = RootW + 2;
  localparam int unsigned DremW  = CompW + 1;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef logic [CompW-1:0] comp_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic [Lanes-1:0]            neg;
    logic                        tneg;
    logic [Lanes-1:0][ProdW-1:0] prod;
    logic [RadW-1:0]             rad;
  } qent_t;

  // Working state of one item in the back pipeline.
  typedef struct packed {
    logic [Lanes-1:0]            neg;
    logic                        tneg;
    logic [Lanes-1:0][ProdW-1:0] prod;
    logic [RadW-1:0]             rad;
    logic [SremW-1:0]            srem;
    logic [RootW-1:0]            root;
    logic [Lanes-1:0]            ovf;
    logic [Lanes-1:0][DremW-1:0] drem;
    logic [Lanes-1:0][CompW-1:0] quo;
  } work_t;

  // One digit of the square root: two radicand bits in, one root bit out.
  function automatic work_t sqrt_step(work_t w);
    work_t          r;
    logic [SremW+1:0] cur;
    logic [SremW+1:0] trial;
    r     = w;
    cur   = {w.srem, w.rad[RadW-1 -: 2]};
    trial = {1'b0, w.root, 2'b01};
    r.rad = {w.rad[RadW-3:0], 2'b00};
    if (cur >= trial) begin
      r.srem = SremW'(cur - trial);
      r.root = {w.root[RootW-2:0], 1'b1};
    end else begin
      r.srem = SremW'(cur);
      r.root = {w.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

  // Overflow check and start of the divisions by the norm.
  function automatic work_t div_setup(work_t w);
    work_t r;
    r = w;
    for (int i = 0; i < Lanes; i++) begin
      r.ovf[i]  = {1'b0, w.prod[i]} >= {w.root, {CompW{1'b0}}};
      r.drem[i] = {1'b0, w.prod[i][ProdW-1 -: CompW]};
      r.quo[i]  = w.prod[i][CompW-1:0];
    end
    return r;
  endfunction

  // One restoring division step on each lane; quo holds the dividend's low
  // bits shifting out while quotient bits shift in.
  function automatic work_t div_step(work_t w);
    work_t            r;
    logic [DremW:0]   t;
    r = w;
    for (int i = 0; i < Lanes; i++) begin
      t = {w.drem[i], w.quo[i][CompW-1]};
      if (t >= {1'b0, w.root}) begin
        r.drem[i] = DremW'(t - {1'b0, w.root});
        r.quo[i]  = {w.quo[i][CompW-2:0], 1'b1};
      end else begin
        r.drem[i] = DremW'(t);
        r.quo[i]  = {w.quo[i][CompW-2:0], 1'b0};
      end
    end
    return r;
  endfunction
endpackage
`default_nettype wire

[sv/vec4_scale_to_length.sv]
`timescale 1ns / 1ps
`default_nettype none
// Four-component vector scaler: out = comp * target_length / floor(sqrt(sum of
// squares)), truncated toward zero and saturated to the signed Q8.16 range.
//
// Input channel: an item (four components and a target length) is taken at a
// rising edge where start is high and busy is low. busy rises only when
// the internal queue is nearly full; since the back part never stalls, in
// practice it stays low and an item can be taken every cycle.
// Output channel: each result appears for exactly one cycle with valid_o high,
// in the order the items were taken. The receiver cannot stall the block.
// From the accepting edge to the valid cycle an item passes one front stage,
// one queue slot, the back input register, 25 square-root digit stages (one
// root bit each), a setup stage, 24 restoring division stages and one output
// register.
// Throughput is one item per cycle, set by the fully pipelined root and divider.
// A zero vector yields a zero result with zero_norm_o set and saturated_o clear.
// Reset clears the valid bits and the queue; no results are in flight after it.
module vec4_scale_to_length (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  v4s_pkg::comp_t       comp_x_i,
  input  v4s_pkg::comp_t       comp_y_i,
  input  v4s_pkg::comp_t       comp_z_i,
  input  v4s_pkg::comp_t       comp_w_i,
  input  v4s_pkg::comp_t       target_length_i,
  output logic                 valid_o,
  output v4s_pkg::comp_t       out_x_o,
  output v4s_pkg::comp_t       out_y_o,
  output v4s_pkg::comp_t       out_z_o,
  output v4s_pkg::comp_t       out_w_o,
  output logic                 zero_norm_o,
  output logic                 saturated_o
);
  import v4s_pkg::*;

  logic             take;
  logic             push, pop;
  qent_t            ent_f, ent_q;
  logic [QCntW-1:0] cnt;
  comp_t [3:0]      comp;
  comp_t [3:0]      res;

  // One item may be in the front stage, so keep one slot in reserve.
  assign busy = (cnt >= QCntW'(QDepth - 1));
  assign take = start && !busy;
  assign comp = {comp_w_i, comp_z_i, comp_y_i, comp_x_i};

  v4s_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .comp_i (comp),
    .tlen_i (target_length_i),
    .push_o (push),
    .ent_o  (ent_f)
  );

  v4s_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ent_i  (ent_f),
    .pop_o  (pop),
    .ent_o  (ent_q),
    .cnt_o  (cnt)
  );

  v4s_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .ent_i       (ent_q),
    .valid_o     (valid_o),
    .res_o       (res),
    .zero_norm_o (zero_norm_o),
    .saturated_o (saturated_o)
  );

  assign out_x_o = res[0];
  assign out_y_o = res[1];
  assign out_z_o = res[2];
  assign out_w_o = res[3];
endmodule
`default_nettype wire

[sv/v4s_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Front part: takes an item, forms magnitudes, products and sum of squares.
// Depends on v4s_pkg.
module v4s_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   take_i,
  input  v4s_pkg::comp_t [3:0]  comp_i,
  input  v4s_pkg::comp_t        tlen_i,
  output logic                  push_o,
  output v4s_pkg::qent_t        ent_o
);
  import v4s_pkg::*;

  logic                        vld_q;
  logic [Lanes-1:0]            neg_q;
  logic                        tneg_q;
  logic [Lanes-1:0][ProdW-1:0] prod_q;
  logic [Lanes-1:0][ProdW-1:0] sq_q;
  logic [Lanes-1:0][CompW-1:0] mag;
  logic [CompW-1:0]            tmag;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      mag[i] = comp_i[i][CompW-1] ? CompW'(~comp_i[i] + 1'b1) : comp_i[i];
    end
    tmag = tlen_i[CompW-1] ? CompW'(~tlen_i + 1'b1) : tlen_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      for (int i = 0; i < Lanes; i++) begin
        neg_q[i]  <= comp_i[i][CompW-1];
        prod_q[i] <= mag[i] * tmag;
        sq_q[i]   <= mag[i] * mag[i];
      end
      tneg_q <= tlen_i[CompW-1];
    end
  end

  assign push_o    = vld_q;
  assign ent_o.neg  = neg_q;
  assign ent_o.tneg = tneg_q;
  assign ent_o.prod = prod_q;
  assign ent_o.rad  = RadW'(sq_q[0]) + RadW'(sq_q[1]) + RadW'(sq_q[2]) + RadW'(sq_q[3]);
endmodule
`default_nettype wire

[sv/v4s_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// Short queue between the front and back parts.
// Depends on v4s_pkg.
module v4s_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  v4s_pkg::qent_t         ent_i,
  output logic                   pop_o,
  output v4s_pkg::qent_t         ent_o,
  output logic [v4s_pkg::QCntW-1:0] cnt_o
);
  import v4s_pkg::*;

  qent_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  // The back part never stalls, so the head leaves whenever there is one.
  assign pop_o = (cnt_q != '0);
  assign ent_o = mem_q[rd_q];
  assign cnt_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_o)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= ent_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth)) else $error("queue count beyond depth");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop_o && cnt_q == QCntW'(QDepth))) else $error("push into full queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_o) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count lost a push");
endmodule
`default_nettype wire

[sv/v4s_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// Back part: pipelined square root, division by the norm, saturation.
// Depends on v4s_pkg.
module v4s_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   pop_i,
  input  v4s_pkg::qent_t        ent_i,
  output logic                  valid_o,
  output v4s_pkg::comp_t [3:0]  res_o,
  output logic                  zero_norm_o,
  output logic                  saturated_o
);
  import v4s_pkg::*;

  localparam int unsigned SqEnd  = RootW;
  localparam int unsigned DivBeg = SqEnd + 1;
  localparam int unsigned NStg   = DivBeg + CompW + 1;

  work_t             stg_q [NStg];
  logic [NStg-1:0]   vld_q;
  work_t             fin;
  comp_t [3:0]       res_d;
  logic              zn_d, sat_d;
  logic              rneg;
  logic              clip;

  assign fin = stg_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      vld_q   <= {vld_q[NStg-2:0], pop_i};
      valid_o <= vld_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q[0].neg  <= ent_i.neg;
    stg_q[0].tneg <= ent_i.tneg;
    stg_q[0].prod <= ent_i.prod;
    stg_q[0].rad  <= ent_i.rad;
    stg_q[0].srem <= '0;
    stg_q[0].root <= '0;
    stg_q[0].ovf  <= '0;
    stg_q[0].drem <= '0;
    stg_q[0].quo  <= '0;
    for (int k = 1; k < NStg; k++) begin
      if (k <= SqEnd) begin
        stg_q[k] <= sqrt_step(stg_q[k-1]);
      end else if (k == DivBeg) begin
        stg_q[k] <= div_setup(stg_q[k-1]);
      end else begin
        stg_q[k] <= div_step(stg_q[k-1]);
      end
    end
  end

  always_comb begin
    sat_d = 1'b0;
    zn_d  = (fin.root == '0);
    res_d = '0;
    rneg  = 1'b0;
    clip  = 1'b0;
    for (int i = 0; i < Lanes; i++) begin
      rneg = (fin.neg[i] != fin.tneg) && (fin.ovf[i] || fin.quo[i] != '0);
      if (rneg) begin
        clip = fin.ovf[i] || (fin.quo[i][CompW-1] && fin.quo[i][CompW-2:0] != '0);
      end else begin
        clip = fin.ovf[i] || fin.quo[i][CompW-1];
      end
      if (clip) begin
        res_d[i] = rneg ? {1'b1, {(CompW-1){1'b0}}} : {1'b0, {(CompW-1){1'b1}}};
        sat_d    = 1'b1;
      end else begin
        res_d[i] = rneg ? CompW'(~fin.quo[i] + 1'b1) : fin.quo[i];
      end
    end
    if (zn_d) begin
      res_d = '0;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o       <= res_d;
    zero_norm_o <= zn_d;
    saturated_o <= sat_d;
  end
endmodule
`default_nettype wire

[bench/vec4_scale_to_length_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the four-component vector scaler (scale to target length).
// Depends on v4s_pkg and vec4_scale_to_length; predicts each result in plain SystemVerilog.
module vec4_scale_to_length_test;
  import v4s_pkg::*;

  // One vector item as it is handed to the block.
  typedef struct {
    comp_t x, y, z, w, len;
  } vec_item_t;

  // One scaled vector as the block should return it.
  typedef struct {
    comp_t x, y, z, w;
    logic  zn, sat;
  } scaled_vec_t;

  localparam int unsigned LatencyCycles = 54;

  logic  clk_i, rst_ni;
  logic  start;
  wire   busy;
  comp_t comp_x_i, comp_y_i, comp_z_i, comp_w_i, target_length_i;
  wire   valid_o, zero_norm_o, saturated_o;
  comp_t out_x_o, out_y_o, out_z_o, out_w_o;

  vec_item_t   pending_vecs[$];
  scaled_vec_t expected_vecs[$];
  int          failures;
  int          send_idle_pct;

  vec4_scale_to_length DUT (
    .clk_i, .rst_ni, .start, .busy,
    .comp_x_i, .comp_y_i, .comp_z_i, .comp_w_i, .target_length_i,
    .valid_o, .out_x_o, .out_y_o, .out_z_o, .out_w_o,
    .zero_norm_o, .saturated_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bit-exact prediction: floor square root of the sum of squares, then an
  // exact product over the norm truncated toward zero and clipped per lane.
  function automatic scaled_vec_t scale_to_length(vec_item_t v);
    scaled_vec_t         r;
    logic signed [23:0]  c[4];
    logic signed [47:0]  tl;
    logic signed [127:0] num, q;
    logic [127:0]        sum, root, cand;
    logic                clip;
    c[0] = v.x; c[1] = v.y; c[2] = v.z; c[3] = v.w;
    tl   = $signed(v.len);
    sum  = '0;
    for (int i = 0; i < 4; i++) begin
      num = c[i];
      sum = sum + 128'(num * num);
    end
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= sum) root = cand;
    end
    r.zn = (root == 0);
    r.sat = 1'b0;
    r.x = '0; r.y = '0; r.z = '0; r.w = '0;
    if (!r.zn) begin
      for (int i = 0; i < 4; i++) begin
        num = 128'(c[i]) * 128'(tl);
        q = num / $signed(root);
        clip = 1'b0;
        if (q > 128'sd8388607) begin
          q = 128'sd8388607; clip = 1'b1;
        end else if (q < -128'sd8388608) begin
          q = -128'sd8388608; clip = 1'b1;
        end
        r.sat |= clip;
        case (i)
          0: r.x = q[23:0];
          1: r.y = q[23:0];
          2: r.z = q[23:0];
          default: r.w = q[23:0];
        endcase
      end
    end
    return r;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return comp_t'($urandom_range(0, 3)) - 24'd1;
      3: return comp_t'($signed(24'($urandom_range(0, 131072))) - 24'sd65536);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic vec_item_t rand_vec();
    vec_item_t v;
    v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp(); v.w = rand_comp();
    // About one vector in three has unit length, so plain normalization is covered often.
    v.len = ($urandom_range(0, 2) == 0) ? 24'd65536 : rand_comp();
    // A few vectors go to zero so the zero-norm path shows up in random traffic.
    if ($urandom_range(0, 30) == 0) begin
      v.x = '0; v.y = '0; v.z = '0; v.w = '0;
    end
    return v;
  endfunction

  function automatic vec_item_t mk(int x, int y, int z, int w, int l);
    vec_item_t v;
    v.x = comp_t'(x); v.y = comp_t'(y); v.z = comp_t'(z); v.w = comp_t'(w);
    v.len = comp_t'(l);
    return v;
  endfunction

  // Driver: start stays high across back-to-back items, with one assignment
  // per step so that the next item never sees a lowered start.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (pending_vecs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        vec_item_t v;
        v = pending_vecs.pop_front();
        comp_x_i <= v.x; comp_y_i <= v.y; comp_z_i <= v.z; comp_w_i <= v.w;
        target_length_i <= v.len;
        expected_vecs.push_back(scale_to_length(v));
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results cannot be held off, so every strobe is checked at once.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_vecs.size() == 0) begin
        $display("%0t: unexpected result x=%h", $realtime, out_x_o);
        failures++;
      end else begin
        scaled_vec_t e;
        e = expected_vecs.pop_front();
        if (out_x_o !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $realtime, e.x, out_x_o);
          failures++;
        end
        if (out_y_o !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $realtime, e.y, out_y_o);
          failures++;
        end
        if (out_z_o !== e.z) begin
          $display("%0t: out_z expected %h actual %h", $realtime, e.z, out_z_o);
          failures++;
        end
        if (out_w_o !== e.w) begin
          $display("%0t: out_w expected %h actual %h", $realtime, e.w, out_w_o);
          failures++;
        end
        if (zero_norm_o !== e.zn) begin
          $display("%0t: zero_norm expected %b actual %b", $realtime, e.zn, zero_norm_o);
          failures++;
        end
        if (saturated_o !== e.sat) begin
          $display("%0t: saturated expected %b actual %b", $realtime, e.sat, saturated_o);
          failures++;
        end
      end
    end
  end

  // Stimulus in phases; each phase waits for the queue of pending items to drain.
  initial begin
    failures = 0;
    send_idle_pct = 9;
    start = 1'b0;
    comp_x_i = '0; comp_y_i = '0; comp_z_i = '0; comp_w_i = '0;
    target_length_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero vector, unit axes, extremes, negative and zero targets,
    // clipping with large targets over small norms.
    pending_vecs.push_back(mk(0, 0, 0, 0, 65536));
    pending_vecs.push_back(mk(0, 0, 0, 0, -8388608));
    pending_vecs.push_back(mk(65536, 0, 0, 0, 65536));
    pending_vecs.push_back(mk(0, -65536, 0, 0, 65536));
    pending_vecs.push_back(mk(3, 4, 0, 0, 65536));
    pending_vecs.push_back(mk(1, 0, 0, 0, 8388607));
    pending_vecs.push_back(mk(-1, 0, 0, 0, 8388607));
    pending_vecs.push_back(mk(1, 0, 0, 0, -8388608));
    pending_vecs.push_back(mk(-1, 0, 0, 0, -8388608));
    pending_vecs.push_back(mk(-8388608, -8388608, -8388608, -8388608, -8388608));
    pending_vecs.push_back(mk(8388607, 8388607, 8388607, 8388607, 8388607));
    pending_vecs.push_back(mk(-8388608, 8388607, -8388608, 8388607, 65536));
    pending_vecs.push_back(mk(123456, -654321, 77, -1, 0));
    pending_vecs.push_back(mk(1, 1, 1, 1, -65536));
    pending_vecs.push_back(mk(-1, -1, -1, -1, 8388607));
    pending_vecs.push_back(mk(0, 0, 0, 1, 1));
    pending_vecs.push_back(mk(0, 0, -3, 0, 65536));
    pending_vecs.push_back(mk(-8388608, 0, 0, 0, 65536));
    wait (pending_vecs.size() == 0);

    for (int i = 0; i < 250; i++) pending_vecs.push_back(rand_vec());
    wait (pending_vecs.size() == 0);
    // Hold off until everything in flight has come back.
    wait (expected_vecs.size() == 0);

    send_idle_pct = 61;
    for (int i = 0; i < 250; i++) pending_vecs.push_back(rand_vec());
    wait (pending_vecs.size() == 0);

    send_idle_pct = 0;
    for (int i = 0; i < 250; i++) pending_vecs.push_back(rand_vec());
    wait (pending_vecs.size() == 0);
    wait (expected_vecs.size() == 0);
    repeat (LatencyCycles + 10) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
